@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL. Synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked property, switched off while reset is high.
`define LPC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds across reset.
`define LPC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LPC_ASSERT(lbl, clk, rst, prop, msg)
`define LPC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/core/lpcsif_pkg.sv @@
package lpcsif_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_ORDER_DEF      = 32;
   localparam int SAMPLE_WIDTH_DEF   = 16;
   localparam int COEF_FRAC_BITS_DEF = 18;

   // Fixed field widths.
   localparam int COEF_WIDTH       = 24;
   localparam int COEF_INDEX_WIDTH = 5;
   localparam int ORDER_WIDTH      = 6;
   localparam int CSR_INDEX_WIDTH  = 4;
   localparam int CSR_DATA_WIDTH   = 8;

   // Register indexes on the configuration channel.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_DIRECTION = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FILTER_ORDER     = 4'd1;

   // Item kinds and filter directions.
   localparam logic MODE_SAMPLE   = 1'b0;
   localparam logic MODE_COEF     = 1'b1;
   localparam logic DIR_SYNTHESIS = 1'b0;
   localparam logic DIR_INVERSE   = 1'b1;

   // Control from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic load;      // start a new sum from the input sample
      logic mul_en;    // operands are valid this cycle
      logic subtract;  // all-pole direction: products are subtracted
      logic finish;    // round, saturate and hold the result
   } mac_ctrl_type;

   // Status from the multiply-accumulate unit.
   typedef struct packed {
      logic busy;       // a product is still on its way into the sum
      logic saturated;  // the held result was clipped
   } mac_stat_type;

endpackage

@@ rtl/core/lpcsif_channels.sv @@
// Sample and coefficient items into the filter.
interface lpcsif_req_if
   import lpcsif_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
   logic                               valid;
   logic                               ready;
   logic                               mode;
   logic signed [SAMPLE_WIDTH-1:0]     sample_in;
   logic                               first_sample;
   logic        [COEF_INDEX_WIDTH-1:0] coef_index;
   logic signed [COEF_WIDTH-1:0]       coef_value;

   modport source (output valid, mode, sample_in, first_sample, coef_index, coef_value,
                   input ready);
   modport sink (input valid, mode, sample_in, first_sample, coef_index, coef_value,
                 output ready);
endinterface

// Filtered samples out of the filter.
interface lpcsif_rsp_if
   import lpcsif_pkg::*;
#(
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
);
   logic                           valid;
   logic                           ready;
   logic signed [SAMPLE_WIDTH-1:0] sample_out;
   logic                           saturated;

   modport source (output valid, sample_out, saturated, input ready);
   modport sink (input valid, sample_out, saturated, output ready);
endinterface

// Register writes.
interface lpcsif_csr_if
   import lpcsif_pkg::*;
;
   logic                       valid;
   logic                       ready;
   logic [CSR_INDEX_WIDTH-1:0] index;
   logic [CSR_DATA_WIDTH-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/lpcsif_ram.sv @@
module lpcsif_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/lpcsif_mac.sv @@
module lpcsif_mac
   import lpcsif_pkg::*;
#(
   parameter int MAX_ORDER      = MAX_ORDER_DEF,
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mac_ctrl_type                   ctrl,
   input  logic signed [SAMPLE_WIDTH-1:0] sample_x,
   input  logic signed [COEF_WIDTH-1:0]   coef_op,
   input  logic signed [SAMPLE_WIDTH-1:0] hist_op,
   output logic signed [SAMPLE_WIDTH-1:0] result,
   output mac_stat_type                   stat
);

   localparam int PW     = COEF_WIDTH + SAMPLE_WIDTH;
   localparam int SUM_W  = PW + $clog2(MAX_ORDER + 1) + 1;
   localparam int LOAD_W = SAMPLE_WIDTH + COEF_FRAC_BITS + 2;
   localparam int ACC_W  = (SUM_W > LOAD_W) ? SUM_W : LOAD_W;
   localparam int RW     = ACC_W + 1 - COEF_FRAC_BITS;
   localparam logic [ACC_W:0] HALF =
      {{(ACC_W + 1 - COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS - 1){1'b0}}};
   localparam logic [SAMPLE_WIDTH-1:0] SAT_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
   localparam logic [SAMPLE_WIDTH-1:0] SAT_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};

   logic signed [PW-1:0]           prod_ff, prod_in;
   logic                           prod_vld_ff;
   logic signed [ACC_W-1:0]        acc_ff, acc_in;
   logic        [SAMPLE_WIDTH-1:0] result_ff, result_in;
   logic                           sat_ff, sat_in;
   logic        [ACC_W:0]          rounded;
   logic        [RW-1:0]           quot;
   logic                           fits;

   // Product of the current tap, registered ahead of the accumulator.
   assign prod_in = coef_op * hist_op;

   // The sum starts at the sample on the coefficient grid and takes one product per cycle.
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.load) begin
         acc_in = ACC_W'(sample_x) <<< COEF_FRAC_BITS;
      end else if (prod_vld_ff) begin
         if (ctrl.subtract) begin
            acc_in = acc_ff - ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // Round half up onto the sample grid, then clip to the sample width.
   always_comb begin
      rounded   = {acc_ff[ACC_W-1], acc_ff} + HALF;
      quot      = rounded[ACC_W:COEF_FRAC_BITS];
      fits      = (quot[RW-1:SAMPLE_WIDTH-1] == '0) || (quot[RW-1:SAMPLE_WIDTH-1] == '1);
      result_in = result_ff;
      sat_in    = sat_ff;
      if (ctrl.finish) begin
         sat_in = !fits;
         if (fits) begin
            result_in = quot[SAMPLE_WIDTH-1:0];
         end else if (quot[RW-1]) begin
            result_in = SAT_MIN;
         end else begin
            result_in = SAT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      result_ff <= result_in;
      sat_ff    <= sat_in;
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctrl.mul_en;
      end
   end

   assign result         = result_ff;
   assign stat.busy      = prod_vld_ff;
   assign stat.saturated = sat_ff;

endmodule

@@ rtl/core/lpc_synthesis_and_inverse_filter.sv @@
// Direct-form LPC filter, all-pole synthesis or FIR inverse, with A(z) = 1 + sum a_k z^-k.
// req_ch carries two kinds of transfer: a coefficient load (mode high) writes one tap
// and gives no result; a sample (mode low) gives exactly one transfer on rsp_ch.
// first_sample on a sample clears the history, so taps before it count as zero.
// csr_ch writes filter_direction (index 0) and filter_order (index 1); it is always
// ready and is meant to be written only while the filter is idle.
// A coefficient load leaves the filter idle. A sample holds off the next transfer until
// it is through: one shared multiply-accumulate unit walks the taps one per cycle, fed
// by the coefficient and history memories, and then drains its pipeline and rounds.
// The result waits in an output register; if the receiver stalls, the next sample is
// still taken and computed, and the filter holds it until the register is free.
// Reset clears the control registers, all taps and the whole history through valid
// bits, so the filter is ready in the cycle after reset falls, with no clearing pass.
`include "assert_macros.svh"

module lpc_synthesis_and_inverse_filter
   import lpcsif_pkg::*;
#(
   parameter int MAX_ORDER      = MAX_ORDER_DEF,
   parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
   parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
   input logic          clock,
   input logic          reset,
   lpcsif_req_if.sink   req_ch,
   lpcsif_rsp_if.source rsp_ch,
   lpcsif_csr_if.sink   csr_ch
);

   localparam int AW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int OW = $clog2(MAX_ORDER + 1);
   // One bit wider than the tap index, so that the store depth itself can be compared.
   localparam int IW = ((AW > COEF_INDEX_WIDTH) ? AW : COEF_INDEX_WIDTH) + 1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_RUN,
      S_DRAIN,
      S_OUT
   } state_type;

   state_type                      state_ff, state_in;
   logic                           dir_ff, dir_in;
   logic        [ORDER_WIDTH-1:0]  order_ff, order_in;
   logic        [AW-1:0]           k_ff, k_in;
   logic        [AW-1:0]           ha_ff, ha_in;
   logic        [AW-1:0]           head_ff, head_in;
   logic signed [SAMPLE_WIDTH-1:0] x_ff, x_in;
   logic                           rd_vld_ff, rd_vld_in;
   logic        [MAX_ORDER-1:0]    coef_vld_ff, coef_vld_in;
   logic        [MAX_ORDER-1:0]    hist_vld_ff, hist_vld_in;
   logic                           cv_rd_ff, cv_rd_in;
   logic                           hv_rd_ff, hv_rd_in;
   logic                           rsp_vld_ff, rsp_vld_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_ff, rsp_sample_in;
   logic                           rsp_sat_ff, rsp_sat_in;

   logic                           req_fire;
   logic [OW-1:0]                  order_lim;
   logic [IW-1:0]                  coef_idx_ext;
   logic [AW-1:0]                  coef_waddr;
   logic                           coef_idx_ok;
   logic [AW-1:0]                  head_next;
   logic [AW-1:0]                  ha_next;
   logic                           coef_we;
   logic                           hist_we;
   logic signed [SAMPLE_WIDTH-1:0] hist_wdata;
   logic                           rd_en;
   logic signed [COEF_WIDTH-1:0]   coef_rdata;
   logic signed [SAMPLE_WIDTH-1:0] hist_rdata;
   logic signed [COEF_WIDTH-1:0]   coef_op;
   logic signed [SAMPLE_WIDTH-1:0] hist_op;
   logic signed [SAMPLE_WIDTH-1:0] mac_result;
   mac_ctrl_type                   mac_ctrl;
   mac_stat_type                   mac_stat;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Taps in use, limited to the store depth.
   always_comb begin
      if ({1'b0, order_ff} > (ORDER_WIDTH + 1)'(MAX_ORDER)) begin
         order_lim = OW'(MAX_ORDER);
      end else begin
         order_lim = OW'(order_ff);
      end
   end

   // Coefficient loads beyond the store depth are dropped.
   assign coef_idx_ext = IW'(req_ch.coef_index);
   assign coef_idx_ok  = (coef_idx_ext < IW'(MAX_ORDER));
   assign coef_waddr   = coef_idx_ext[AW-1:0];

   // The history is a ring: head points at the newest sample and the walk runs backwards.
   assign head_next = (head_ff == AW'(MAX_ORDER - 1)) ? '0 : head_ff + 1'b1;
   assign ha_next   = (ha_ff == '0) ? AW'(MAX_ORDER - 1) : ha_ff - 1'b1;

   // Sequencer and output register.
   always_comb begin
      state_in      = state_ff;
      dir_in        = dir_ff;
      order_in      = order_ff;
      k_in          = k_ff;
      ha_in         = ha_ff;
      head_in       = head_ff;
      x_in          = x_ff;
      rd_vld_in     = 1'b0;
      coef_vld_in   = coef_vld_ff;
      hist_vld_in   = hist_vld_ff;
      cv_rd_in      = coef_vld_ff[k_ff];
      hv_rd_in      = hist_vld_ff[ha_ff];
      rsp_vld_in    = rsp_vld_ff && !rsp_ch.ready;
      rsp_sample_in = rsp_sample_ff;
      rsp_sat_in    = rsp_sat_ff;
      coef_we       = 1'b0;
      hist_we       = 1'b0;
      hist_wdata    = (dir_ff == DIR_INVERSE) ? x_ff : mac_result;
      mac_ctrl          = '0;
      mac_ctrl.subtract = (dir_ff == DIR_SYNTHESIS);
      mac_ctrl.mul_en   = rd_vld_ff;

      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_FILTER_DIRECTION: dir_in = csr_ch.data[0];
            CSR_FILTER_ORDER:     order_in = csr_ch.data[ORDER_WIDTH-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_ch.mode == MODE_COEF) begin
                  if (coef_idx_ok) begin
                     coef_we                 = 1'b1;
                     coef_vld_in[coef_waddr] = 1'b1;
                  end
               end else begin
                  mac_ctrl.load = 1'b1;
                  x_in          = req_ch.sample_in;
                  k_in          = '0;
                  ha_in         = head_ff;
                  if (req_ch.first_sample) begin
                     hist_vld_in = '0;
                  end
                  state_in = (order_lim == '0) ? S_DRAIN : S_RUN;
               end
            end
         end
         S_RUN: begin
            // One tap a cycle: coefficient k against history entry k.
            rd_vld_in = 1'b1;
            k_in      = k_ff + 1'b1;
            ha_in     = ha_next;
            if (OW'(k_ff) + OW'(1) == order_lim) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // Wait until the last product has reached the sum.
            if (!rd_vld_ff && !mac_stat.busy) begin
               mac_ctrl.finish = 1'b1;
               state_in        = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_vld_ff || rsp_ch.ready) begin
               hist_we              = 1'b1;
               head_in              = head_next;
               hist_vld_in[head_next] = 1'b1;
               rsp_vld_in           = 1'b1;
               rsp_sample_in        = mac_result;
               rsp_sat_in           = mac_stat.saturated;
               state_in             = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      x_in_hold: begin
         x_ff          <= x_in;
         cv_rd_ff      <= cv_rd_in;
         hv_rd_ff      <= hv_rd_in;
         rsp_sample_ff <= rsp_sample_in;
         rsp_sat_ff    <= rsp_sat_in;
      end
      if (reset) begin
         state_ff    <= S_IDLE;
         dir_ff      <= DIR_SYNTHESIS;
         order_ff    <= '0;
         k_ff        <= '0;
         ha_ff       <= '0;
         head_ff     <= '0;
         rd_vld_ff   <= 1'b0;
         coef_vld_ff <= '0;
         hist_vld_ff <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         dir_ff      <= dir_in;
         order_ff    <= order_in;
         k_ff        <= k_in;
         ha_ff       <= ha_in;
         head_ff     <= head_in;
         rd_vld_ff   <= rd_vld_in;
         coef_vld_ff <= coef_vld_in;
         hist_vld_ff <= hist_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   assign rsp_ch.valid      = rsp_vld_ff;
   assign rsp_ch.sample_out = rsp_sample_ff;
   assign rsp_ch.saturated  = rsp_sat_ff;

   // Coefficient and history memories, read together once per tap.
   assign rd_en = (state_ff == S_RUN);

   lpcsif_ram #(
      .WIDTH (COEF_WIDTH),
      .DEPTH (MAX_ORDER)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (coef_waddr),
      .wr_data (req_ch.coef_value),
      .rd_en   (rd_en),
      .rd_addr (k_ff),
      .rd_data (coef_rdata)
   );

   lpcsif_ram #(
      .WIDTH (SAMPLE_WIDTH),
      .DEPTH (MAX_ORDER)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (hist_we),
      .wr_addr (head_next),
      .wr_data (hist_wdata),
      .rd_en   (rd_en),
      .rd_addr (ha_ff),
      .rd_data (hist_rdata)
   );

   // Entries never written since reset or since the last clear read as zero.
   assign coef_op = cv_rd_ff ? coef_rdata : '0;
   assign hist_op = hv_rd_ff ? hist_rdata : '0;

   lpcsif_mac #(
      .MAX_ORDER      (MAX_ORDER),
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .sample_x (req_ch.sample_in),
      .coef_op  (coef_op),
      .hist_op  (hist_op),
      .result   (mac_result),
      .stat     (mac_stat)
   );

   // Checks on the sequencer.
   `LPC_ASSERT(a_read_from_run, clock, reset, rd_vld_ff |-> $past(state_ff == S_RUN), "tap read outside the tap walk")
   `LPC_ASSERT(a_tap_in_range, clock, reset, (state_ff == S_RUN) |-> (OW'(k_ff) < order_lim), "tap walk beyond the filter order")
   `LPC_ASSERT(a_hist_then_rsp, clock, reset, hist_we |=> (state_ff == S_IDLE) && rsp_vld_ff, "history advanced without a result")
   `LPC_ASSERT_ALWAYS(a_reset_idle, clock, $past(reset) |-> (state_ff == S_IDLE) && !rsp_vld_ff, "not idle after reset")

endmodule

@@ verif/lpc_synthesis_and_inverse_filter_tb.sv @@
module lpc_synthesis_and_inverse_filter_tb;
   import lpcsif_pkg::*;

   localparam int SW          = SAMPLE_WIDTH_DEF;
   localparam int CW          = COEF_WIDTH;
   localparam int FRAC        = COEF_FRAC_BITS_DEF;
   localparam int TAPS        = MAX_ORDER_DEF;
   // Leave a margin before register writes.
   localparam int SETTLE      = 64;
   localparam int QUIET_LIMIT = 4000;

   typedef struct {
      logic                  mode;
      logic signed [SW-1:0]  sample_in;
      logic                  first_sample;
      logic [COEF_INDEX_WIDTH-1:0] coef_index;
      logic signed [CW-1:0]  coef_value;
   } filter_item_type;

   typedef struct {
      logic signed [SW-1:0] sample_out;
      logic                 saturated;
   } filter_output_type;

   logic clock = 1'b0;
   logic reset;

   lpcsif_req_if req_ch ();
   lpcsif_rsp_if rsp_ch ();
   lpcsif_csr_if csr_ch ();

   lpc_synthesis_and_inverse_filter dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // Shadow copy of the filter state.
   logic signed [CW-1:0]   coef_taps [TAPS];
   logic signed [SW-1:0]   past_samples [TAPS];
   logic                   cur_direction;
   logic [ORDER_WIDTH-1:0] cur_order;

   filter_output_type expected_outputs [$];
   filter_output_type due;
   int error_count;
   int quiet_cycles;
   int sender_gap_pct;
   int receiver_stall_pct;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver stalls at random, decided at each falling edge.
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   // Each result transfer is compared with the oldest expected output.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_outputs.size() == 0) begin
            $error("result transfer with no expected output: sample_out %0d saturated %0b",
                   rsp_ch.sample_out, rsp_ch.saturated);
            error_count++;
         end else begin
            due = expected_outputs.pop_front();
            if (rsp_ch.sample_out !== due.sample_out) begin
               $error("sample_out: expected %0d, got %0d", due.sample_out, rsp_ch.sample_out);
               error_count++;
            end
            if (rsp_ch.saturated !== due.saturated) begin
               $error("saturated: expected %0b, got %0b", due.saturated, rsp_ch.saturated);
               error_count++;
            end
         end
      end
   end

   // Ends the run when no transfer of any kind has happened for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Applies one accepted item to the shadow state and queues any output it causes.
   task automatic filter_model_step(input filter_item_type it);
      longint acc;
      longint y;
      longint prod;
      int taps;
      filter_output_type r;
      if (it.mode == MODE_COEF) begin
         if (it.coef_index < TAPS) coef_taps[it.coef_index] = it.coef_value;
         return;
      end
      if (it.first_sample) begin
         foreach (past_samples[k]) past_samples[k] = '0;
      end
      taps = (cur_order > TAPS) ? TAPS : int'(cur_order);
      acc = longint'(it.sample_in) <<< FRAC;
      for (int k = 0; k < taps; k++) begin
         prod = longint'(coef_taps[k]) * longint'(past_samples[k]);
         if (cur_direction == DIR_INVERSE) acc += prod;
         else acc -= prod;
      end
      acc += longint'(1) <<< (FRAC - 1);
      y = acc >>> FRAC;
      r.saturated = 1'b0;
      if (y > (longint'(1) <<< (SW - 1)) - 1) begin
         y = (longint'(1) <<< (SW - 1)) - 1;
         r.saturated = 1'b1;
      end
      if (y < -(longint'(1) <<< (SW - 1))) begin
         y = -(longint'(1) <<< (SW - 1));
         r.saturated = 1'b1;
      end
      r.sample_out = y[SW-1:0];
      for (int k = TAPS - 1; k > 0; k--) past_samples[k] = past_samples[k-1];
      past_samples[0] = (cur_direction == DIR_INVERSE) ? it.sample_in : r.sample_out;
      expected_outputs.push_back(r);
   endtask

   function automatic filter_item_type make_sample(input logic signed [SW-1:0] x,
                                                   input logic first);
      filter_item_type it;
      it.mode         = MODE_SAMPLE;
      it.sample_in    = x;
      it.first_sample = first;
      it.coef_index   = COEF_INDEX_WIDTH'($urandom);
      it.coef_value   = CW'($urandom);
      return it;
   endfunction

   function automatic filter_item_type make_coef(input int idx,
                                                 input logic signed [CW-1:0] val);
      filter_item_type it;
      it.mode         = MODE_COEF;
      it.sample_in    = SW'($urandom);
      it.first_sample = 1'($urandom);
      it.coef_index   = COEF_INDEX_WIDTH'(idx);
      it.coef_value   = val;
      return it;
   endfunction

   // Random value scaled down by an arithmetic shift, so small shifts reach the extremes.
   function automatic logic signed [CW-1:0] random_coef(input int shift);
      logic signed [CW-1:0] raw;
      raw = CW'($urandom);
      return raw >>> shift;
   endfunction

   function automatic logic signed [SW-1:0] random_sample();
      logic signed [SW-1:0] raw;
      raw = SW'($urandom);
      return ($urandom_range(3) == 0) ? (raw >>> $urandom_range(1, 12)) : raw;
   endfunction

   // Offers one item, with random gaps before it, and waits for its transfer.
   task automatic send_item(input filter_item_type it);
      while ($urandom_range(99) < sender_gap_pct) begin
         @(negedge clock);
         req_ch.valid <= 1'b0;
      end
      @(negedge clock);
      req_ch.valid        <= 1'b1;
      req_ch.mode         <= it.mode;
      req_ch.sample_in    <= it.sample_in;
      req_ch.first_sample <= it.first_sample;
      req_ch.coef_index   <= it.coef_index;
      req_ch.coef_value   <= it.coef_value;
      do @(posedge clock); while (!req_ch.ready);
      filter_model_step(it);
   endtask

   // Stops offering items until every expected output has arrived.
   task automatic wait_drained(input int settle);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_outputs.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      if (idx == CSR_FILTER_DIRECTION) cur_direction = data[0];
      else if (idx == CSR_FILTER_ORDER) cur_order = data[ORDER_WIDTH-1:0];
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Registers change only once the filter has gone idle.
   task automatic configure(input logic direction, input int order);
      wait_drained(SETTLE);
      write_register(CSR_FILTER_DIRECTION, CSR_DATA_WIDTH'(direction));
      write_register(CSR_FILTER_ORDER, CSR_DATA_WIDTH'(order));
   endtask

   task automatic test_directed();
      filter_item_type it;
      sender_gap_pct     = 30;
      receiver_stall_pct = 30;
      // With order zero the samples pass straight through.
      send_item(make_sample(16'sh7FFF, 1'b1));
      send_item(make_sample(16'sh8000, 1'b0));
      send_item(make_sample(16'sh0000, 1'b0));
      // Extreme coefficients at both ends of the index range.
      send_item(make_coef(0, 24'sh800000));
      send_item(make_coef(TAPS - 1, 24'sh7FFFFF));
      send_item(make_coef(1, 24'sh040000));
      // An order above the maximum is treated as the maximum.
      configure(DIR_SYNTHESIS, 63);
      send_item(make_sample(16'sh7FFF, 1'b1));
      send_item(make_sample(16'sh8000, 1'b0));
      send_item(make_sample(16'sh8000, 1'b0));
      // The direction changes in mid-stream; the synthesis history is reused as it is.
      configure(DIR_INVERSE, TAPS);
      send_item(make_sample(16'sd12345, 1'b0));
      send_item(make_sample(-16'sd1, 1'b0));
      // A new coefficient takes effect on the very next sample.
      send_item(make_coef(0, 24'sh7FFFFF));
      send_item(make_sample(16'sh7FFF, 1'b0));
      // A coefficient load with the first-sample flag leaves the history alone.
      it = make_coef(2, -24'sd262144);
      it.first_sample = 1'b1;
      send_item(it);
      send_item(make_sample(16'sh8000, 1'b0));
      // The first-sample flag clears the history.
      send_item(make_sample(-16'sd1, 1'b1));
      send_item(make_sample(16'sd1, 1'b0));
      // Halfway values round towards plus infinity in both directions.
      configure(DIR_SYNTHESIS, 1);
      send_item(make_coef(0, 24'sh020000));
      send_item(make_sample(16'sd1, 1'b1));
      send_item(make_sample(16'sd0, 1'b0));
      configure(DIR_INVERSE, 1);
      send_item(make_sample(16'sd1, 1'b1));
      send_item(make_sample(16'sd0, 1'b0));
      configure(DIR_INVERSE, 0);
      send_item(make_sample(16'sh8000, 1'b0));
   endtask

   // Frames of well-formed traffic: an optional new setting, a tap load, then samples
   // mostly starting with a history clear, sprinkled with stray loads and clears.
   task automatic test_random_frames(input int n_items, input int gap_pct,
                                     input int stall_pct);
      int sent;
      int pick;
      int order;
      int shift;
      int frame_len;
      sender_gap_pct     = gap_pct;
      receiver_stall_pct = stall_pct;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(3) == 0) begin
            pick = $urandom_range(9);
            if (pick == 0) order = 0;
            else if (pick == 1) order = TAPS;
            else if (pick == 2) order = $urandom_range(TAPS + 1, (1 << ORDER_WIDTH) - 1);
            else if (pick <= 4) order = $urandom_range(9, TAPS - 1);
            else order = $urandom_range(1, 8);
            configure(1'($urandom_range(1)), order);
         end
         shift = ($urandom_range(7) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 10);
         if ($urandom_range(1) == 0) begin
            for (int k = 0; k < ((cur_order > TAPS) ? TAPS : int'(cur_order)); k++) begin
               send_item(make_coef(k, random_coef(shift)));
               sent++;
            end
         end else begin
            repeat ($urandom_range(0, 3)) begin
               send_item(make_coef($urandom_range(TAPS - 1), random_coef(shift)));
               sent++;
            end
         end
         frame_len = $urandom_range(4, 24);
         for (int i = 0; i < frame_len; i++) begin
            if ($urandom_range(19) == 0) begin
               send_item(make_coef($urandom_range(TAPS - 1), random_coef($urandom_range(12))));
               sent++;
            end
            send_item(make_sample(random_sample(),
                                  (i == 0) ? ($urandom_range(5) != 0) : ($urandom_range(40) == 0)));
            sent++;
         end
         // Now and then the sender holds off until the filter has caught up.
         if ($urandom_range(9) == 0) wait_drained(0);
      end
   endtask

   initial begin
      error_count        = 0;
      sender_gap_pct     = 0;
      receiver_stall_pct = 0;
      reset              = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.mode         = MODE_SAMPLE;
      req_ch.sample_in    = '0;
      req_ch.first_sample = 1'b0;
      req_ch.coef_index   = '0;
      req_ch.coef_value   = '0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.index        = CSR_FILTER_DIRECTION;
      csr_ch.data         = '0;
      foreach (coef_taps[k]) coef_taps[k] = '0;
      foreach (past_samples[k]) past_samples[k] = '0;
      cur_direction = DIR_SYNTHESIS;
      cur_order     = '0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_frames(230, 11, 70);
      test_random_frames(230, 70, 11);
      test_random_frames(240, 0, 0);

      wait_drained(SETTLE);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/lpcsif_pkg.sv
rtl/core/lpcsif_channels.sv
rtl/core/lpcsif_ram.sv
rtl/core/lpcsif_mac.sv
rtl/core/lpc_synthesis_and_inverse_filter.sv
verif/lpc_synthesis_and_inverse_filter_tb.sv
